// ----- rtl/pidr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pidr_pkg;

	// sample and duty formats
	localparam int SAMPLE_BITS    = 12;
	localparam int DUTY_FRAC_BITS = 28;
	localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
	localparam int GAIN_W         = 16;
	localparam int ERR_W          = SAMPLE_BITS + 1;
	localparam int CMP_W          = GAIN_W;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = DUTY_W + 1;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = PROD_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DUTY_W;

	localparam longint unsigned DUTY_ONE   = 64'd1 << DUTY_FRAC_BITS;
	localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

	// reset values: 1.2 V of 3.3 V full scale, duty limits 0.05 and 0.85
	localparam logic [SAMPLE_BITS-1:0] TARGET_RST = SAMPLE_BITS'((4 * SAMPLE_MAX + 5) / 11);
	localparam logic [GAIN_W-1:0]      KP_RST     = GAIN_W'(4326);
	localparam logic [GAIN_W-1:0]      KI_RST     = GAIN_W'(108);
	localparam logic [DUTY_W-1:0]      FLOOR_RST  = DUTY_W'((DUTY_ONE + 10) / 20);
	localparam logic [DUTY_W-1:0]      CEIL_RST   = DUTY_W'((17 * DUTY_ONE + 10) / 20);
	localparam logic [SAMPLE_BITS-1:0] OC_RST     = SAMPLE_BITS'(SAMPLE_MAX);
	localparam logic [GAIN_W-1:0]      PERIOD_RST = GAIN_W'(4999);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_KP      = 3'd1,
		REG_KI      = 3'd2,
		REG_FLOOR   = 3'd3,
		REG_CEIL    = 3'd4,
		REG_OC      = 3'd5,
		REG_PERIOD  = 3'd6,
		REG_UNUSED  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] target_counts;
		logic [GAIN_W-1:0]      prop_gain;
		logic [GAIN_W-1:0]      integ_gain;
		logic [DUTY_W-1:0]      duty_floor;
		logic [DUTY_W-1:0]      duty_ceiling;
		logic [SAMPLE_BITS-1:0] overcurrent_counts;
		logic [GAIN_W-1:0]      pwm_period;
	} cfg_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

// ----- rtl/pi_duty_regulator.sv -----
// pi regulator for a pwm stage: each transfer on the input channel carries one
// voltage and one current adc sample, and one transfer on the output channel
// returns the pwm compare value and the overcurrent fault flag. a normal sample
// passes through these steps before the next input transfer can be taken
// (multiply ki*err, clamp integrator while multiplying kp*err, clamp duty,
// multiply duty*period, load output); an overcurrent sample only multiplies
// duty*period and loads the output. the sequence is set by the single shared
// 30x17 multiplier, used three times per normal sample and once per overcurrent sample.
// the input side stalls while a sample is in work and while a finished result
// cannot yet enter the output register. the output register lets the next
// sample enter while the previous result still waits. configuration is taken
// on any cycle (cfg_ready is always high) but should be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module pi_duty_regulator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [pidr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pidr_pkg::CFG_DATA_W-1:0]       cfg_data,
	// sample input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [pidr_pkg::SAMPLE_BITS-1:0]      volt_sample,
	input  wire logic [pidr_pkg::SAMPLE_BITS-1:0]      curr_sample,
	// result output channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [pidr_pkg::CMP_W-1:0]                 compare_value,
	output logic                                       fault
);

	pidr_pkg::cfg_t                         cfg;
	pidr_pkg::mul_req_t                     mul_req;
	logic signed [pidr_pkg::PROD_W-1:0]     prod;

	// register file: setpoint, gains, duty limits, current limit, period
	pidr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// shared multiplier with registered product
	pidr_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// sequencer, integrator, clamp/adder and output register
	pidr_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.volt_sample   (volt_sample),
		.curr_sample   (curr_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.compare_value (compare_value),
		.fault         (fault),
		.mul_req       (mul_req),
		.prod          (prod)
	);

endmodule

`default_nettype wire

// ----- rtl/pidr_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pidr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pidr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pidr_pkg::cfg_t                          cfg
);

	pidr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_counts      <= pidr_pkg::TARGET_RST;
			cfg_q.prop_gain          <= pidr_pkg::KP_RST;
			cfg_q.integ_gain         <= pidr_pkg::KI_RST;
			cfg_q.duty_floor         <= pidr_pkg::FLOOR_RST;
			cfg_q.duty_ceiling       <= pidr_pkg::CEIL_RST;
			cfg_q.overcurrent_counts <= pidr_pkg::OC_RST;
			cfg_q.pwm_period         <= pidr_pkg::PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (pidr_pkg::reg_idx_t'(cfg_index))
				pidr_pkg::REG_TARGET: cfg_q.target_counts <= cfg_data[pidr_pkg::SAMPLE_BITS-1:0];
				pidr_pkg::REG_KP:     cfg_q.prop_gain     <= cfg_data[pidr_pkg::GAIN_W-1:0];
				pidr_pkg::REG_KI:     cfg_q.integ_gain    <= cfg_data[pidr_pkg::GAIN_W-1:0];
				pidr_pkg::REG_FLOOR:  cfg_q.duty_floor    <= cfg_data[pidr_pkg::DUTY_W-1:0];
				pidr_pkg::REG_CEIL:   cfg_q.duty_ceiling  <= cfg_data[pidr_pkg::DUTY_W-1:0];
				pidr_pkg::REG_OC: begin
					cfg_q.overcurrent_counts <= cfg_data[pidr_pkg::SAMPLE_BITS-1:0];
				end
				pidr_pkg::REG_PERIOD: cfg_q.pwm_period    <= cfg_data[pidr_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidr_mul (
	input  wire logic                                  clk,
	input  pidr_pkg::mul_req_t                         req,
	output logic signed [pidr_pkg::PROD_W-1:0]         prod
);

	logic signed [pidr_pkg::PROD_W-1:0] full;
	logic signed [pidr_pkg::PROD_W-1:0] prod_q;

	// signed operands, full-width exact product
	assign full = req.a * req.b;
	assign prod = prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= full;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidr_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidr_seq (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  pidr_pkg::cfg_t                              cfg,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [pidr_pkg::SAMPLE_BITS-1:0]       volt_sample,
	input  wire logic [pidr_pkg::SAMPLE_BITS-1:0]       curr_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [pidr_pkg::CMP_W-1:0]                  compare_value,
	output logic                                        fault,
	output pidr_pkg::mul_req_t                          mul_req,
	input  wire logic signed [pidr_pkg::PROD_W-1:0]     prod
);

	localparam int SUM_W   = pidr_pkg::SUM_W;
	localparam int DUTY_W  = pidr_pkg::DUTY_W;
	localparam int SCALE_W = pidr_pkg::PROD_W - pidr_pkg::DUTY_FRAC_BITS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL_I = 6'b000010,
		ST_ADD_I = 6'b000100,
		ST_ADD_P = 6'b001000,
		ST_MUL_S = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// ceiling tested first, floor second: floor wins when limits cross
	function automatic logic [DUTY_W-1:0] clamp_duty(
		input logic signed [SUM_W-1:0] v,
		input logic [DUTY_W-1:0]       lo,
		input logic [DUTY_W-1:0]       hi
	);
		logic signed [SUM_W-1:0] lo_s;
		logic signed [SUM_W-1:0] hi_s;
		logic signed [SUM_W-1:0] r;
		lo_s = {{(SUM_W-DUTY_W){1'b0}}, lo};
		hi_s = {{(SUM_W-DUTY_W){1'b0}}, hi};
		r = v;
		if (r > hi_s) r = hi_s;
		if (r < lo_s) r = lo_s;
		return r[DUTY_W-1:0];
	endfunction

	state_t                               state_q;
	logic [DUTY_W-1:0]                    integ_q;
	logic                                 out_valid_q;
	logic signed [pidr_pkg::ERR_W-1:0]    err_q;
	logic [DUTY_W-1:0]                    duty_q;
	logic                                 fault_q;
	logic [pidr_pkg::CMP_W-1:0]           out_cmp_q;
	logic                                 out_fault_q;

	logic                                 accept;
	logic                                 overcurrent;
	logic                                 out_free;
	logic signed [SUM_W-1:0]              sum;
	logic [DUTY_W-1:0]                    sum_clamped;
	logic [SCALE_W-1:0]                   scaled;
	logic [pidr_pkg::CMP_W-1:0]           cmp_sat;

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign overcurrent   = (curr_sample > cfg.overcurrent_counts);
	assign out_free      = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign compare_value = out_cmp_q;
	assign fault         = out_fault_q;

	// shared adder: integrator plus the product of the previous cycle
	assign sum         = $signed({{(SUM_W-DUTY_W){1'b0}}, integ_q}) + $signed({prod[pidr_pkg::PROD_W-1], prod});
	assign sum_clamped = clamp_duty(sum, cfg.duty_floor, cfg.duty_ceiling);

	// duty times period, truncating shift and saturation
	assign scaled  = prod[pidr_pkg::PROD_W-1:pidr_pkg::DUTY_FRAC_BITS];
	assign cmp_sat = (|scaled[SCALE_W-1:pidr_pkg::CMP_W]) ? {pidr_pkg::CMP_W{1'b1}}
	                                                     : scaled[pidr_pkg::CMP_W-1:0];

	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			ST_MUL_I: begin
				mul_req.en = 1'b1;
				mul_req.a  = pidr_pkg::MUL_A_W'(err_q);
				mul_req.b  = $signed({1'b0, cfg.integ_gain});
			end
			ST_ADD_I: begin
				mul_req.en = 1'b1;
				mul_req.a  = pidr_pkg::MUL_A_W'(err_q);
				mul_req.b  = $signed({1'b0, cfg.prop_gain});
			end
			ST_MUL_S: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, duty_q});
				mul_req.b  = $signed({1'b0, cfg.pwm_period});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drained result; a load in the emit state takes over the flag
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (overcurrent) begin
							integ_q <= cfg.duty_floor;
							state_q <= ST_MUL_S;
						end else begin
							state_q <= ST_MUL_I;
						end
					end
				end
				ST_MUL_I: state_q <= ST_ADD_I;
				ST_ADD_I: begin
					integ_q <= sum_clamped;
					state_q <= ST_ADD_P;
				end
				ST_ADD_P: state_q <= ST_MUL_S;
				ST_MUL_S: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= $signed({1'b0, cfg.target_counts}) - $signed({1'b0, volt_sample});
			fault_q <= overcurrent;
			duty_q  <= cfg.duty_floor;
		end
		if (state_q == ST_ADD_P) begin
			duty_q <= sum_clamped;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_cmp_q   <= cmp_sat;
			out_fault_q <= fault_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pidr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [pidr_pkg::CMP_W-1:0]    compare_value,
	input wire logic                          fault
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(compare_value) && $stable(fault))
		else $error("output payload changed while stalled");

	// the block is busy for the cycles after an input transfer
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

	a_busy_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 in_stall)
		else $error("input not stalled two cycles after transfer");

	// a new result only appears out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule

bind pi_duty_regulator pidr_checker u_pidr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.compare_value (compare_value),
	.fault         (fault)
);

`default_nettype wire
